>>> hdl/dqmq_pkg.sv
// shared types and op codes for the deque with minimum query
// no dependencies; used by deque_with_min_query_unit
package dqmq_pkg;

    // op codes of a command word
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_MIN        = 3'd4;

    // command word
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } cmd_t;

    // response word
    typedef struct packed {
        logic signed [31:0] result_value;
        logic               result_valid;
        logic [6:0]         occupancy;
        logic               push_dropped;
    } rsp_t;

endpackage

>>> hdl/dqmq_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module dqmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/deque_with_min_query_unit.sv
// deque of signed values in a ring buffer with pop and minimum query
// push, empty pop, empty query and unused ops answer from the hold state; a pop
// does one ram read; the minimum query scans the deque through the single ram
// read port one entry per cycle. one command in flight at a time.
// reset: front index, count, state and output valid clear; the ram is not
// cleared and needs no clearing pass. depends on dqmq_pkg and dqmq_ram
module deque_with_min_query_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  dqmq_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dqmq_pkg::rsp_t rsp
);

    import dqmq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = $clog2(2 * DEPTH);

    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [IDX_W-1:0]             front_reg, front_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    rsp_t                         rsp_reg, rsp_next;
    rsp_t                         pend_reg, pend_next;
    logic [IDX_W-1:0]             scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0]             scan_left_reg, scan_left_next;
    logic                         first_reg, first_next;
    logic signed [DATA_WIDTH-1:0] best_reg, best_next;

    logic                         we;
    logic [IDX_W-1:0]             waddr;
    logic [IDX_W-1:0]             raddr;
    logic signed [DATA_WIDTH-1:0] wdata;
    logic signed [DATA_WIDTH-1:0] rdata;

    logic                         accept;
    logic                         out_free;
    logic                         full;
    logic                         empty;
    logic [IDX_W-1:0]             front_dec;
    logic [IDX_W-1:0]             front_inc;
    logic [IDX_W-1:0]             scan_inc;
    logic [IDX_W-1:0]             back_slot;
    logic [IDX_W-1:0]             tail_slot;
    logic signed [DATA_WIDTH-1:0] best_cand;
    rsp_t                         done_word;

    // reduce a sum below twice the depth into a ring index
    function automatic logic [IDX_W-1:0] ring(input logic [SUM_W-1:0] s);
        if (s >= DEPTH_S)
        begin
            ring = IDX_W'(s - DEPTH_S);
        end
        else
        begin
            ring = IDX_W'(s);
        end
    endfunction

    dqmq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // handshake
    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ring pointers
    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign scan_inc  = (scan_addr_reg == LAST_IDX) ? '0 : scan_addr_reg + 1'b1;
    assign back_slot = ring(SUM_W'(front_reg) + SUM_W'(count_reg));
    assign tail_slot = ring(SUM_W'(front_reg) + SUM_W'(count_reg) - SUM_W'(1));

    // pushed value sign-extended or cut to the stored width
    assign wdata = DATA_WIDTH'(cmd.value);

    // running minimum of the scan
    always_comb
    begin
        if (first_reg || (rdata < best_reg))
        begin
            best_cand = rdata;
        end
        else
        begin
            best_cand = best_reg;
        end
    end

    // response word finished in the pop or scan state
    always_comb
    begin
        done_word              = '0;
        done_word.result_valid = 1'b1;
        done_word.occupancy    = 7'(count_reg);
        if (state_reg == S_SCAN)
        begin
            done_word.result_value = 32'(best_cand);
        end
        else
        begin
            done_word.result_value = 32'(rdata);
        end
    end

    // control sequencer
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        pend_next      = pend_reg;
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        first_next     = first_reg;
        best_next      = best_reg;
        we             = 1'b0;
        waddr          = back_slot;
        raddr          = scan_addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_next  = '0;
                    state_next = S_HOLD;
                    case (cmd.op)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                pend_next.push_dropped = 1'b1;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                pend_next.push_dropped = 1'b1;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = back_slot;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (!empty)
                            begin
                                raddr      = front_reg;
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (!empty)
                            begin
                                raddr      = tail_slot;
                                count_next = count_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        OP_MIN:
                        begin
                            if (!empty)
                            begin
                                raddr          = front_reg;
                                scan_addr_next = front_inc;
                                scan_left_next = count_reg - 1'b1;
                                first_next     = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            pend_next = '0;
                        end
                    endcase
                    pend_next.occupancy = 7'(count_next);
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    rsp_next       = done_word;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    pend_next  = done_word;
                    state_next = S_HOLD;
                end
            end
            S_SCAN:
            begin
                best_next = best_cand;
                if (scan_left_reg != '0)
                begin
                    raddr          = scan_addr_reg;
                    scan_addr_next = scan_inc;
                    scan_left_next = scan_left_reg - 1'b1;
                    first_next     = 1'b0;
                end
                else if (out_free)
                begin
                    rsp_next       = done_word;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    pend_next  = done_word;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        rsp_reg       <= rsp_next;
        pend_reg      <= pend_next;
        scan_addr_reg <= scan_addr_next;
        scan_left_reg <= scan_left_next;
        first_reg     <= first_next;
        best_reg      <= best_next;
    end

endmodule
